/* src/sfq_pkg.sv */
// shared constants and request/status codes for the searchable fifo queue
package sfq_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  localparam int REQ_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [REQ_W-1:0] REQ_ENQ    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DEQ    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LIST   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

/* src/sfq_store.sv */
// entry store: single write port, single registered read port
module sfq_store #(
  parameter int DEPTH      = sfq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = sfq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]                 wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]                 rdata
);
  import sfq_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/searchable_fifo_queue_core.sv */
// searchable fifo queue: top level with request sequencer and entry walk
//
//  channel   signals                                   handshake
//  request   req_type, value                           start, taken when busy low
//  result    status, data, found, count, last          result_valid, one cycle
//
//  enqueue, clear, unknown and empty cases: result in the cycle after acceptance
//  dequeue: the head entry is read through the registered store port, then the result is registered; busy until then
//  search and list: busy for the whole walk, one entry per cycle through the
//  single read port of the entry store; list results come one per cycle
//  reset clears state, indices, fill count, left, rd_pend and result_valid only, the store needs no clearing pass
//  results cannot be stalled
module searchable_fifo_queue_core #(
  parameter int DEPTH      = sfq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = sfq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic        [sfq_pkg::REQ_W-1:0]    req_type,
  input  logic signed [sfq_pkg::VALUE_W-1:0]  value,
  output logic                                result_valid,
  output logic        [sfq_pkg::STATUS_W-1:0] status,
  output logic signed [sfq_pkg::VALUE_W-1:0]  data,
  output logic                                found,
  output logic        [sfq_pkg::COUNT_W-1:0]  count,
  output logic                                last
);
  import sfq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DX_W  = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int CX_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  typedef enum logic {S_IDLE, S_WALK} state_t;
  typedef enum logic [1:0] {OP_DEQ, OP_SEARCH, OP_LIST} op_t;

  state_t                state;
  op_t                   op;
  logic [PTR_W-1:0]      head;
  logic [PTR_W-1:0]      tail;
  logic [CNT_W-1:0]      fill;
  logic [CNT_W-1:0]      fill_next;
  logic [PTR_W-1:0]      slot;
  logic [CNT_W-1:0]      left;
  logic                  rd_pend;
  logic                  rd_last;
  logic                  hit;
  logic [DATA_WIDTH-1:0] key;

  logic                  accept;
  logic                  we;
  logic                  re;
  logic [PTR_W-1:0]      raddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata;
  logic                  match;
  logic [DX_W-1:0]       rdata_x;
  logic [CX_W-1:0]       fill_x;
  logic [CX_W-1:0]       fill_next_x;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign wdata       = DATA_WIDTH'($unsigned(value));
  assign we          = accept && (req_type == REQ_ENQ) && (fill != FULL_CNT);
  assign match       = (rdata == key);
  assign rdata_x     = DX_W'(rdata);
  assign fill_x      = CX_W'(fill);
  assign fill_next_x = CX_W'(fill_next);

  // walk read: one entry a cycle while entries remain
  always_comb begin
    re    = (state == S_WALK) && (left != '0);
    raddr = slot;
  end

  always_comb begin
    fill_next = fill;
    case (req_type)
      REQ_ENQ: begin
        if (fill != FULL_CNT) begin
          fill_next = fill + 1'b1;
        end
      end
      REQ_DEQ: begin
        if (fill != '0) begin
          fill_next = fill - 1'b1;
        end
      end
      REQ_CLEAR: begin
        fill_next = '0;
      end
      default: begin
        fill_next = fill;
      end
    endcase
  end

  sfq_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (tail),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      tail         <= '0;
      fill         <= '0;
      left         <= '0;
      rd_pend      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            fill   <= fill_next;
            status <= ST_OK;
            data   <= '0;
            found  <= 1'b0;
            count  <= fill_next_x[COUNT_W-1:0];
            last   <= 1'b1;
            key    <= wdata;
            hit    <= 1'b0;
            slot   <= head;
            left   <= fill;
            case (req_type)
              REQ_ENQ: begin
                result_valid <= 1'b1;
                if (fill == FULL_CNT) begin
                  status <= ST_FULL;
                end else begin
                  tail <= next_slot(tail);
                end
              end
              REQ_DEQ: begin
                if (fill == '0) begin
                  result_valid <= 1'b1;
                  status       <= ST_EMPTY;
                end else begin
                  head  <= next_slot(head);
                  left  <= CNT_W'(1);
                  op    <= OP_DEQ;
                  state <= S_WALK;
                end
              end
              REQ_SEARCH: begin
                if (fill == '0) begin
                  result_valid <= 1'b1;
                end else begin
                  op    <= OP_SEARCH;
                  state <= S_WALK;
                end
              end
              REQ_CLEAR: begin
                result_valid <= 1'b1;
                head         <= '0;
                tail         <= '0;
              end
              REQ_LIST: begin
                if (fill == '0) begin
                  result_valid <= 1'b1;
                  status       <= ST_EMPTY;
                end else begin
                  op    <= OP_LIST;
                  state <= S_WALK;
                end
              end
              default: begin
                result_valid <= 1'b1;
              end
            endcase
          end
        end
        S_WALK: begin
          if (left != '0) begin
            slot    <= next_slot(slot);
            left    <= left - 1'b1;
            rd_pend <= 1'b1;
            rd_last <= (left == CNT_W'(1));
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            status <= ST_OK;
            data   <= '0;
            found  <= 1'b0;
            count  <= fill_x[COUNT_W-1:0];
            last   <= rd_last;
            case (op)
              OP_SEARCH: begin
                hit <= hit | match;
                if (rd_last) begin
                  result_valid <= 1'b1;
                  found        <= hit | match;
                end
              end
              OP_DEQ, OP_LIST: begin
                result_valid <= 1'b1;
                data         <= rdata_x[VALUE_W-1:0];
              end
              default: begin
                result_valid <= 1'b0;
              end
            endcase
            if (rd_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_CNT)
    else $error("fill count beyond depth");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!rd_pend && (left == '0 || !busy)))
    else $error("read pending while idle");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_ENQ && fill != FULL_CNT) |=>
      (fill == $past(fill) + 1'b1))
    else $error("enqueue did not grow the queue");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && rd_pend && rd_last) |=> (state == S_IDLE && result_valid))
    else $error("walk did not finish with a result");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    busy |-> !we)
    else $error("store written during a walk");

endmodule
